>>> hdl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW   = 32;
  localparam int SAMPLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(MAX_WINDOW);
  localparam int CNT_W        = 6;

  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [CNT_W-1:0]               count_t;

  localparam count_t MAX_COUNT           = count_t'(MAX_WINDOW);
  localparam count_t WINDOW_LENGTH_RESET = count_t'(20);

  // register index (word address) of window_length
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // command to the sorted-list merge engine
  typedef struct packed {
    logic    start;
    logic    del_en;     // remove one copy of del_value
    logic    ins_en;     // insert ins_value, marks the final pass of a transaction
    sample_t del_value;
    sample_t ins_value;
    count_t  src_count;  // entries in the current sorted list
    idx_t    rank;       // output index whose value is the median
  } merge_cmd_t;

  typedef struct packed {
    logic   done;
    count_t count;       // entries in the new sorted list
  } merge_sts_t;

endpackage

>>> hdl/swm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_if
// Valid/ready channels for samples in and medians out.
// ----------------------------------------------------------------------------
interface swm_sample_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_result_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t median;
  swm_pkg::count_t  fill_count;

  modport source (output valid, output median, output fill_count, input ready);
  modport sink   (input valid, input median, input fill_count, output ready);
endinterface

>>> hdl/swm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_merge
// Sorted list of held samples, double-buffered in one RAM; one pass streams
// the list and writes it back with one value removed and/or one inserted.
// ----------------------------------------------------------------------------
module swm_merge (
  input  logic                clk,
  input  logic                rst,
  input  swm_pkg::merge_cmd_t cmd,
  output swm_pkg::merge_sts_t sts,
  output swm_pkg::sample_t    median
);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_START = 4'b0010,
    M_RUN   = 4'b0100,
    M_TAIL  = 4'b1000
  } merge_state_t;

  merge_state_t state, state_next;

  // two banks, selected by the address MSB
  swm_pkg::sample_t mem [2*swm_pkg::MAX_WINDOW];
  swm_pkg::sample_t rdata;

  logic             bank;
  logic             del_en, ins_en, del_done, ins_done;
  logic             del_done_next, ins_done_next;
  swm_pkg::sample_t del_value, ins_value;
  swm_pkg::count_t  src_count, wr_count;
  swm_pkg::idx_t    rank, rd_idx, rd_idx_next, rd_sel;
  logic             rd_en, wr_en, done;
  swm_pkg::sample_t wr_data;
  swm_pkg::count_t  last_idx;

  assign last_idx = src_count - swm_pkg::count_t'(1);

  always_comb begin
    state_next    = state;
    rd_en         = 1'b0;
    rd_sel        = rd_idx;
    rd_idx_next   = rd_idx;
    wr_en         = 1'b0;
    wr_data       = rdata;
    del_done_next = del_done;
    ins_done_next = ins_done;
    done          = 1'b0;
    case (state)
      M_IDLE: begin
        if (cmd.start) begin
          del_done_next = 1'b0;
          ins_done_next = 1'b0;
          state_next    = M_START;
        end
      end
      M_START: begin
        if (src_count != '0) begin
          rd_en       = 1'b1;
          rd_sel      = '0;
          rd_idx_next = '0;
          state_next  = M_RUN;
        end else begin
          state_next = M_TAIL;
        end
      end
      M_RUN: begin
        if (ins_en && !ins_done && (ins_value < rdata)) begin
          // insert ahead of this entry, then read it again
          wr_en         = 1'b1;
          wr_data       = ins_value;
          ins_done_next = 1'b1;
          rd_en         = 1'b1;
          rd_sel        = rd_idx;
        end else begin
          if (del_en && !del_done && (rdata == del_value)) begin
            del_done_next = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
          if ({1'b0, rd_idx} == last_idx) begin
            state_next = M_TAIL;
          end else begin
            rd_en       = 1'b1;
            rd_sel      = rd_idx + swm_pkg::idx_t'(1);
            rd_idx_next = rd_idx + swm_pkg::idx_t'(1);
          end
        end
      end
      M_TAIL: begin
        if (ins_en && !ins_done) begin
          wr_en   = 1'b1;
          wr_data = ins_value;
        end
        done       = 1'b1;
        state_next = M_IDLE;
      end
      default: begin
        state_next = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[{bank, rd_sel}];
    end
    if (wr_en) begin
      mem[{~bank, wr_count[swm_pkg::IDX_W-1:0]}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      bank     <= 1'b0;
      del_done <= 1'b0;
      ins_done <= 1'b0;
      wr_count <= '0;
    end else begin
      state    <= state_next;
      del_done <= del_done_next;
      ins_done <= ins_done_next;
      rd_idx   <= rd_idx_next;
      if (state == M_IDLE && cmd.start) begin
        del_en    <= cmd.del_en;
        ins_en    <= cmd.ins_en;
        del_value <= cmd.del_value;
        ins_value <= cmd.ins_value;
        src_count <= cmd.src_count;
        rank      <= cmd.rank;
        wr_count  <= '0;
      end else if (wr_en) begin
        wr_count <= wr_count + swm_pkg::count_t'(1);
      end
      if (done) begin
        bank <= ~bank;
      end
    end
  end

  // pick off the median as the final pass writes it
  always_ff @(posedge clk) begin
    if (wr_en && ins_en && (wr_count == {1'b0, rank})) begin
      median <= wr_data;
    end
  end

  assign sts.done  = done;
  assign sts.count = wr_count + swm_pkg::count_t'(wr_en);

endmodule

>>> hdl/sliding_window_median_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running median over the newest window_length samples.
// ----------------------------------------------------------------------------
// Channels: samples (sink) carries one signed sample per transaction; medians
// (source) returns one transaction per sample with the value at rank
// fill_count/2 of the held samples sorted ascending, and fill_count.
// window_length is written over the APB port at byte address 0; the user
// must do so only while idle (not enforced); 0 acts as 1, above 32 as 32.
// Samples live in a circular RAM; a sorted copy lives in a second,
// double-banked RAM. Each sample costs one merge pass over the sorted list
// that inserts the new sample and, once the window is full, also drops the
// oldest one. After window_length is lowered, each excess sample dropped
// costs one more pass. The merge pass, one RAM read per cycle, sets the
// rate; one sample at a time. Reset empties the window (no clearing pass)
// and sets window_length to 20. A finished result waits in the output
// register; a new sample is taken while it waits, and the next result is
// held back until it has been taken.
// ----------------------------------------------------------------------------
module sliding_window_median_unit (
  input  logic                              clk,
  input  logic                              rst,
  swm_sample_if.sink                        samples,
  swm_result_if.source                      medians,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  typedef enum logic [4:0] {
    T_IDLE   = 5'b00001,
    T_FETCH  = 5'b00010,
    T_LAUNCH = 5'b00100,
    T_WAIT   = 5'b01000,
    T_FINISH = 5'b10000
  } top_state_t;

  top_state_t state;

  swm_pkg::count_t     window_length;
  swm_pkg::count_t     held_count, drops_left, target;
  swm_pkg::idx_t       oldest_position, slot;
  swm_pkg::sample_t    ins_value, win_rdata, med_value;
  logic                last_pass, del_pass;
  logic                out_valid;
  swm_pkg::sample_t    out_median;
  swm_pkg::count_t     out_fill;

  swm_pkg::sample_t    sample_window [swm_pkg::MAX_WINDOW];

  swm_pkg::merge_cmd_t cmd;
  swm_pkg::merge_sts_t sts;

  logic                accept, out_free, finish;
  swm_pkg::count_t     eff_len, cnt_plus;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_LENGTH)
                  ? {{(swm_pkg::APB_DATA_W-swm_pkg::CNT_W){1'b0}}, window_length}
                  : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swm_pkg::WINDOW_LENGTH_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_LENGTH)) begin
      window_length <= pwdata[swm_pkg::CNT_W-1:0];
    end
  end

  // ---------------- control ----------------
  assign accept   = samples.valid && samples.ready;
  assign out_free = !out_valid || medians.ready;
  assign finish   = (state == T_FINISH) && out_free;

  assign samples.ready = (state == T_IDLE);

  always_comb begin
    if (window_length == '0) begin
      eff_len = swm_pkg::count_t'(1);
    end else if (window_length > swm_pkg::MAX_COUNT) begin
      eff_len = swm_pkg::MAX_COUNT;
    end else begin
      eff_len = window_length;
    end
  end

  assign cnt_plus = held_count + swm_pkg::count_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      held_count      <= '0;
      oldest_position <= '0;
      drops_left      <= '0;
      last_pass       <= 1'b0;
      del_pass        <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            ins_value <= samples.sample;
            slot      <= oldest_position + held_count[swm_pkg::IDX_W-1:0];
            if (cnt_plus > eff_len) begin
              drops_left <= cnt_plus - eff_len;
              target     <= eff_len;
              state      <= T_FETCH;
            end else begin
              drops_left <= '0;
              target     <= cnt_plus;
              last_pass  <= 1'b1;
              del_pass   <= 1'b0;
              state      <= T_LAUNCH;
            end
          end
        end
        T_FETCH: begin
          oldest_position <= oldest_position + swm_pkg::idx_t'(1);
          drops_left      <= drops_left - swm_pkg::count_t'(1);
          last_pass       <= (drops_left == swm_pkg::count_t'(1));
          del_pass        <= 1'b1;
          state           <= T_LAUNCH;
        end
        T_LAUNCH: begin
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (sts.done) begin
            held_count <= sts.count;
            state      <= (drops_left != '0) ? T_FETCH : T_FINISH;
          end
        end
        T_FINISH: begin
          if (out_free) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // ---------------- circular sample store ----------------
  always_ff @(posedge clk) begin
    if (state == T_FETCH) begin
      win_rdata <= sample_window[oldest_position];
    end
    if (finish) begin
      sample_window[slot] <= ins_value;
    end
  end

  // ---------------- sorted list ----------------
  always_comb begin
    cmd.start     = (state == T_LAUNCH);
    cmd.del_en    = del_pass;
    cmd.ins_en    = last_pass;
    cmd.del_value = win_rdata;
    cmd.ins_value = ins_value;
    cmd.src_count = held_count;
    cmd.rank      = target[swm_pkg::IDX_W:1];
  end

  swm_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .median (med_value)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (medians.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_median <= med_value;
      out_fill   <= target;
    end
  end

  assign medians.valid      = out_valid;
  assign medians.median     = out_median;
  assign medians.fill_count = out_fill;

endmodule

>>> tb/swm_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_median_checker
// Watches the sample, median and APB ports of the median unit. It tracks the
// window_length register, keeps its own circular copy of the held samples,
// ranks them on every sample transaction and checks each median transaction
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module swm_median_checker
  import swm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  swm_sample_if                 samples,
  swm_result_if                 medians,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    sample_t median;
    count_t  fill_count;
  } median_rec_t;

  sample_t     window_mem [MAX_WINDOW];
  int unsigned held_n;
  int unsigned oldest_idx;
  count_t      window_code;
  median_rec_t expected_medians [$];
  int          fails;
  int          seen;

  // Store the new sample, drop whatever no longer fits, rank what is held.
  function automatic median_rec_t push_sample(input sample_t s);
    sample_t     ranked [MAX_WINDOW];
    sample_t     v;
    int unsigned eff;
    int unsigned n;
    int unsigned j;
    median_rec_t r;
    if (window_code == 0)
      eff = 1;
    else if (window_code > MAX_WINDOW)
      eff = MAX_WINDOW;
    else
      eff = window_code;
    window_mem[(oldest_idx + held_n) % MAX_WINDOW] = s;
    n = held_n + 1;
    if (n > eff) begin
      // a lowered window sheds all excess oldest samples at once
      oldest_idx = (oldest_idx + n - eff) % MAX_WINDOW;
      n = eff;
    end
    held_n = n;
    for (int i = 0; i < n; i++) begin
      v = window_mem[(oldest_idx + i) % MAX_WINDOW];
      j = i;
      while (j > 0 && ranked[j-1] > v) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = v;
    end
    r.median     = ranked[n/2];
    r.fill_count = count_t'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    median_rec_t want;
    if (rst) begin
      held_n      = 0;
      oldest_idx  = 0;
      window_code = WINDOW_LENGTH_RESET;
      expected_medians.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH)
        window_code = pwdata[CNT_W-1:0];

      // retire before predicting: a median can never belong to this cycle's sample
      if (medians.valid && medians.ready) begin
        seen++;
        if (expected_medians.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected median transaction: median %0d fill %0d",
                     $realtime, medians.median, medians.fill_count);
        end else begin
          want = expected_medians[0];
          expected_medians.delete(0);
          if (medians.median !== want.median || medians.fill_count !== want.fill_count) begin
            fails++;
            if (fails <= 10)
              $display("%0t: median mismatch: expected %0d fill %0d, got %0d fill %0d",
                       $realtime, want.median, want.fill_count,
                       medians.median, medians.fill_count);
          end
        end
      end

      if (samples.valid && samples.ready)
        expected_medians.insert(expected_medians.size(), push_sample(samples.sample));
    end
    fail_count <= fails;
    pending    <= expected_medians.size();
    checked    <= seen;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for sliding_window_median_unit. A directed opening
// covers sample extremes, code 0, over-range codes, an unused register word
// and a window shrunk below its fill; random phases follow at many window
// settings with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import swm_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 64;
  localparam int STALL_CYCLES     = 600;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int RANDOM_PHASES    = 12;
  localparam int MAX_GAP          = 16;

  localparam int IDLE_NONE  = 0;
  localparam int IDLE_FULL  = 1;
  localparam int IDLE_LIGHT = 2;

  localparam logic [APB_ADDR_W-1:0] WINDOW_LENGTH_ADDR = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR      = {~REG_WINDOW_LENGTH, 2'b00};

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int      fail_count;
  int      pending;
  int      checked;
  int      cycle_cnt;
  int      samples_sent   = 0;
  int      settings_used  = 0;
  int      send_style     = IDLE_FULL;
  int      recv_style     = IDLE_FULL;
  bit      hold_off       = 1'b0;
  bit      pressure_go    = 1'b0;
  sample_t last_sample    = '0;

  swm_sample_if sample_ch ();
  swm_result_if median_ch ();

  sliding_window_median_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .medians (median_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swm_median_checker median_chk (
    .clk        (clk),
    .rst        (rst),
    .samples    (sample_ch),
    .medians    (median_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int draw_gap(input int style);
    case (style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, MAX_GAP);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  // wide values, tight clusters (lots of ties), extremes, repeats and ramps
  function automatic sample_t draw_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = sample_t'($urandom());
      4, 5:       s = sample_t'(int'($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0:       s = SAMPLE_MAX;
          1:       s = SAMPLE_MIN;
          2:       s = -16'sd1;
          default: s = '0;
        endcase
      end
      7:          s = last_sample;
      8:          s = last_sample + 16'sd1;
      default:    s = last_sample - sample_t'($urandom_range(0, 3));
    endcase
    last_sample = s;
    return s;
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_sample(input sample_t s);
    int gap;
    gap = draw_gap(send_style);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic window_write(input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_phase(input count_t code, input bit with_stall);
    logic [APB_DATA_W-1:0] word;
    // upper bits are don't-care for the register; toggle them anyway
    word = ($urandom() & ~32'h3F) | APB_DATA_W'(code);
    window_write(WINDOW_LENGTH_ADDR, word);
    if (with_stall)
      pressure_go = 1'b1;
    for (int i = 0; i < RANDOM_PER_PHASE; i++)
      send_sample(draw_sample());
    drain();
  endtask

  initial begin : median_sink
    int gap;
    median_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = draw_gap(recv_style);
      if (gap > 0 || hold_off) begin
        median_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      median_ch.ready <= 1'b1;
      @(posedge clk);
      while (!median_ch.valid) @(posedge clk);
    end
  end

  // long output stall so the unit backs up and stops taking samples
  initial begin : output_hold
    wait (pressure_go);
    hold_off = 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d medians outstanding", cycle_cnt, pending);
    $display("** sliding_window_median_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    count_t window_codes [RANDOM_PHASES];
    window_codes = '{6'd32, 6'd1, 6'd17, 6'd63, 6'd4, 6'd0,
                     6'd32, 6'd2, 6'd33, 6'd9, 6'd31, 6'd3};
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length of 20, window never fills here
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(-16'sd1);
    send_sample(-16'sd1);
    drain();

    // code 0 behaves as a window of one
    window_write(WINDOW_LENGTH_ADDR, '0);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    send_sample(SAMPLE_MAX);
    drain();

    // over-range code saturates to the full window
    window_write(WINDOW_LENGTH_ADDR, 32'd40);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd7);
    drain();

    // the unused register word must not touch the window length
    window_write(UNMAPPED_ADDR, 32'd2);
    send_sample(16'sd5);
    send_sample(16'sd5);
    send_sample(-16'sd5);
    drain();

    // shrink to 2 with 6 held: the next sample drops the excess
    window_write(WINDOW_LENGTH_ADDR, 32'hFFFF_FFC2);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_style = (p == 0) ? IDLE_NONE : p % 3;
      recv_style = (p + 1) % 3;
      random_phase(window_codes[p], p == 0);
    end

    $display("Ran %0d samples and checked %0d medians across %0d register writes,",
             samples_sent, checked, settings_used);
    $display("window codes 0..63 incl. over-range, plus a %0d-cycle output stall.",
             STALL_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("** sliding_window_median_unit: PASSED **");
    end else begin
      $display("%0d failures, %0d medians never arrived", fail_count, pending);
      $display("** sliding_window_median_unit: FAILED **");
    end
    $finish;
  end

endmodule
